@@ hdl/c5rc_pkg.sv @@
// c5rc_pkg: shared types and constants for the 5x5 four-channel convolution core
// used by conv5x5_rgba_clamp_core and the testbench; no dependencies
`default_nettype none
package c5rc_pkg;
	localparam int MAX_WIDTH = 4096;
	localparam int TAPS      = 5;
	localparam int LINES     = TAPS - 1;
	localparam int NCOEF     = TAPS * TAPS;
	localparam int FRAC_BITS = 12;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int PIX_W     = 32;
	localparam int LINE_W    = PIX_W * LINES;
	localparam int PROD_W    = 24;
	localparam int GRP_W     = PROD_W + 3;
	localparam int SUM_W     = PROD_W + 5;
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef enum logic [2:0] {
		REG_PADDED_WIDTH = 3'd0,
		REG_COEF_PACK_0  = 3'd1,
		REG_COEF_PACK_1  = 3'd2,
		REG_COEF_PACK_2  = 3'd3,
		REG_COEF_PACK_3  = 3'd4,
		REG_COEF_PACK_4  = 3'd5,
		REG_COEF_PACK_5  = 3'd6,
		REG_COEF_LAST    = 3'd7
	} reg_idx_t;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [COL_W-1:0] col_t;
endpackage
`default_nettype wire

@@ hdl/c5rc_ram.sv @@
// c5rc_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none
module c5rc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ hdl/conv5x5_rgba_clamp_core.sv @@
// conv5x5_rgba_clamp_core: streaming 5x5 convolution of a padded rgba image
// depends on c5rc_pkg and c5rc_ram
//
// channel  | direction | content
// s_axis   | in        | tdata = ch0..ch3 from bit 0, tuser = frame_start
// m_axis   | out       | tdata = ch0..ch3 from bit 0, tlast = row_end
// apb      | in/out    | 8 registers at 8*i, 64-bit data, pready tied high
//
// one pixel per cycle while s_axis_tready is high; the line store ram is read
// and written back once per pixel, a write-to-read bypass covers the same column
// twice in a row; a result passes stages s1 to s5, then an 8-deep output fifo
// s_axis_tready drops when the fifo plus in-flight results would overfill
// no clearing pass after reset: the line store holds four rows per entry
`default_nettype none
module conv5x5_rgba_clamp_core (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [31:0] s_axis_tdata,  // in_ch0, in_ch1, in_ch2, in_ch3
	input  wire         s_axis_tuser,  // frame_start
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [31:0] m_axis_tdata,  // out_ch0, out_ch1, out_ch2, out_ch3
	output logic        m_axis_tlast,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [5:0]  paddr,
	input  wire  [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);
	import c5rc_pkg::*;

	// configuration
	logic [12:0] padded_width_q;
	logic [63:0] coef_pack_q [6];
	logic [15:0] coef_last_q;
	logic signed [15:0] coef [NCOEF];
	reg_idx_t    cfg_idx;
	logic        cfg_wr;

	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[5:3]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			padded_width_q <= 13'd4096;
			for (int i = 0; i < 6; i++) coef_pack_q[i] <= '0;
			coef_pack_q[3] <= 64'd4096;
			coef_last_q    <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_PADDED_WIDTH: padded_width_q <= pwdata[12:0];
				REG_COEF_PACK_0:  coef_pack_q[0] <= pwdata;
				REG_COEF_PACK_1:  coef_pack_q[1] <= pwdata;
				REG_COEF_PACK_2:  coef_pack_q[2] <= pwdata;
				REG_COEF_PACK_3:  coef_pack_q[3] <= pwdata;
				REG_COEF_PACK_4:  coef_pack_q[4] <= pwdata;
				REG_COEF_PACK_5:  coef_pack_q[5] <= pwdata;
				REG_COEF_LAST:    coef_last_q    <= pwdata[15:0];
				default:          coef_last_q    <= coef_last_q;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_PADDED_WIDTH: prdata = {51'd0, padded_width_q};
			REG_COEF_PACK_0:  prdata = coef_pack_q[0];
			REG_COEF_PACK_1:  prdata = coef_pack_q[1];
			REG_COEF_PACK_2:  prdata = coef_pack_q[2];
			REG_COEF_PACK_3:  prdata = coef_pack_q[3];
			REG_COEF_PACK_4:  prdata = coef_pack_q[4];
			REG_COEF_PACK_5:  prdata = coef_pack_q[5];
			REG_COEF_LAST:    prdata = {48'd0, coef_last_q};
			default:          prdata = '0;
		endcase
	end

	always_comb begin
		for (int k = 0; k < NCOEF - 1; k++) begin
			coef[k] = coef_pack_q[k / 4][16 * (k % 4) +: 16];
		end
		coef[NCOEF-1] = coef_last_q;
	end

	// width clamp and counters, input stage
	logic [12:0] eff_w;
	col_t        col_q, col_eff;
	logic [2:0]  row_q, row_eff;
	logic        s_acc, last_s0, emit_s0;

	always_comb begin
		priority if (padded_width_q < 13'd5)              eff_w = 13'd5;
		else if (padded_width_q > 13'(MAX_WIDTH))         eff_w = 13'(MAX_WIDTH);
		else                                              eff_w = padded_width_q;
	end

	assign s_acc   = s_axis_tvalid && s_axis_tready;
	assign col_eff = s_axis_tuser ? '0 : col_q;
	assign row_eff = s_axis_tuser ? '0 : row_q;
	assign last_s0 = {1'b0, col_eff} >= (eff_w - 13'd1);
	assign emit_s0 = (row_eff >= 3'(LINES)) && (col_eff >= COL_W'(LINES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (s_acc) begin
			if (last_s0) begin
				col_q <= '0;
				if (row_eff < 3'(LINES)) row_q <= row_eff + 3'd1;
				else                     row_q <= row_eff;
			end else begin
				col_q <= col_eff + COL_W'(1);
				row_q <= row_eff;
			end
		end
	end

	// line store: one entry per column, four stacked rows, oldest in the low word
	logic              v_s1, emit_s1, last_s1;
	col_t              addr_s1;
	pix_t              pix_s1;
	logic [LINE_W-1:0] ram_rd, line_s1, line_wr;
	logic              wr_v_q;
	col_t              wr_addr_q;
	logic [LINE_W-1:0] wr_data_q;

	c5rc_ram #(.WIDTH(LINE_W), .DEPTH(MAX_WIDTH)) u_line (
		.clk   (clk),
		.we    (v_s1),
		.waddr (addr_s1),
		.wdata (line_wr),
		.raddr (col_eff),
		.rdata (ram_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			emit_s1 <= 1'b0;
			wr_v_q  <= 1'b0;
		end else begin
			v_s1    <= s_acc;
			emit_s1 <= s_acc && emit_s0;
			wr_v_q  <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1   <= col_eff;
		pix_s1    <= s_axis_tdata;
		last_s1   <= last_s0;
		wr_addr_q <= addr_s1;
		wr_data_q <= line_wr;
	end

	// bypass when the same column was written on the edge the read was taken
	assign line_s1 = (wr_v_q && wr_addr_q == addr_s1) ? wr_data_q : ram_rd;
	assign line_wr = {pix_s1, line_s1[LINE_W-1:PIX_W]};

	// window, row-major, column 0 oldest
	pix_t win_q [NCOEF];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NCOEF; k++) win_q[k] <= '0;
		end else if (v_s1) begin
			for (int y = 0; y < TAPS; y++) begin
				for (int x = 0; x < TAPS - 1; x++) win_q[y*TAPS + x] <= win_q[y*TAPS + x + 1];
				if (y < LINES) win_q[y*TAPS + TAPS - 1] <= line_s1[PIX_W*y +: PIX_W];
				else           win_q[y*TAPS + TAPS - 1] <= pix_s1;
			end
		end
	end

	// products, group sums, total; the window holds the s1 pixel from s2 on
	logic emit_s2, v_s3, v_s4, v_s5, last_s2, last_s3, last_s4, last_s5;
	logic signed [PROD_W-1:0] prod_s3 [4][NCOEF];
	logic signed [GRP_W-1:0]  grp_s4  [4][TAPS];
	logic signed [SUM_W-1:0]  sum_s5  [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s2 <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
		end else begin
			emit_s2 <= emit_s1;
			v_s3    <= emit_s2;
			v_s4    <= v_s3;
			v_s5    <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		last_s2 <= last_s1;
		last_s3 <= last_s2;
		last_s4 <= last_s3;
		last_s5 <= last_s4;
		for (int ch = 0; ch < 4; ch++) begin
			for (int k = 0; k < NCOEF; k++) begin
				prod_s3[ch][k] <= PROD_W'($signed({1'b0, win_q[k][8*ch +: 8]}))
				                * PROD_W'(coef[k]);
			end
			for (int g = 0; g < TAPS; g++) begin
				grp_s4[ch][g] <= GRP_W'(prod_s3[ch][g*TAPS]) + GRP_W'(prod_s3[ch][g*TAPS+1])
				               + GRP_W'(prod_s3[ch][g*TAPS+2]) + GRP_W'(prod_s3[ch][g*TAPS+3])
				               + GRP_W'(prod_s3[ch][g*TAPS+4]);
			end
			sum_s5[ch] <= SUM_W'(grp_s4[ch][0]) + SUM_W'(grp_s4[ch][1]) + SUM_W'(grp_s4[ch][2])
			            + SUM_W'(grp_s4[ch][3]) + SUM_W'(grp_s4[ch][4]);
		end
	end

	// floor and clamp
	logic [31:0] res_s5;

	always_comb begin
		for (int ch = 0; ch < 4; ch++) begin
			priority if (sum_s5[ch][SUM_W-1])
				res_s5[8*ch +: 8] = 8'd0;
			else if (|sum_s5[ch][SUM_W-2:FRAC_BITS+8])
				res_s5[8*ch +: 8] = 8'hff;
			else
				res_s5[8*ch +: 8] = sum_s5[ch][FRAC_BITS +: 8];
		end
	end

	// output fifo
	logic [32:0]        fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]   cnt_q;
	logic [2:0]         inflight;
	logic               pop;

	assign inflight      = 3'(emit_s1) + 3'(emit_s2) + 3'(v_s3) + 3'(v_s4) + 3'(v_s5);
	assign s_axis_tready = (cnt_q + (FIFO_AW+1)'(inflight)) < (FIFO_AW+1)'(FIFO_DEPTH);
	assign m_axis_tvalid = cnt_q != '0;
	assign pop           = m_axis_tvalid && m_axis_tready;
	assign m_axis_tdata  = fifo_q[rd_ptr_q][31:0];
	assign m_axis_tlast  = fifo_q[rd_ptr_q][32];

	always_ff @(posedge clk) begin
		if (v_s5) fifo_q[wr_ptr_q] <= {last_s5, res_s5};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (v_s5) wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			cnt_q <= cnt_q + (FIFO_AW+1)'(v_s5) - (FIFO_AW+1)'(pop);
		end
	end

`ifndef SYNTHESIS
	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q + (FIFO_AW+1)'(inflight)) <= (FIFO_AW+1)'(FIFO_DEPTH))
		else $error("output fifo credit overrun");
	a_row_sat: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= 3'(LINES))
		else $error("row counter beyond saturation");
	a_frame: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && s_axis_tuser |=> col_q == COL_W'(1) && row_q == 3'd0)
		else $error("frame start did not restart counters");
	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		emit_s1 |-> v_s1)
		else $error("result flagged without a pixel");
`endif
endmodule
`default_nettype wire

@@ dv/testbench.sv @@
// testbench for conv5x5_rgba_clamp_core: streams padded rgba frames through the
// core and checks every output pixel against an in-bench 5x5 convolution predictor
// depends on c5rc_pkg and the core rtl only
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import c5rc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 20;
	localparam int TARGET_PIXELS = 1050;

	typedef enum int {K_IDENT, K_RAND, K_MAXPOS, K_MAXNEG, K_BOX, K_MILD} coef_kind_t;

	typedef struct {
		logic [31:0] pix;
		logic        fs;
		bit          typed;
		logic [32:0] want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;   // in_ch0, in_ch1, in_ch2, in_ch3
	logic        s_axis_tuser = 1'b0; // frame_start
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;        // out_ch0, out_ch1, out_ch2, out_ch3
	logic        m_axis_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [5:0]  paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic        pready;

	conv5x5_rgba_clamp_core DUT (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor state
	logic [12:0]        width_reg = 13'd4096;
	logic signed [15:0] coef [NCOEF];
	logic [31:0]        lstore [LINES][MAX_WIDTH];
	logic [31:0]        win [NCOEF];
	int                 col_cnt = 0;
	int                 row_cnt = 0;

	logic [32:0] pending_out [$];   // {row_end, pixel}
	int          errors = 0;
	int          cycles = 0;
	int          pixels_sent = 0;
	int          burst_left = 0;
	bit          no_gaps = 0;

	task automatic report_err(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	function automatic void convolve_pixel(input logic [31:0] pix, input logic fs,
			output bit emit, output logic [32:0] res);
		int w, c, ch, k;
		logic [31:0] colpx [TAPS];
		longint acc;
		bit last;
		w = width_reg;
		if (w < 5) w = 5;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		if (fs) begin
			col_cnt = 0;
			row_cnt = 0;
		end
		c = (col_cnt >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_cnt;
		for (int y = 0; y < LINES; y++)
			colpx[y] = lstore[y][c];
		colpx[LINES] = pix;
		for (int y = 0; y + 1 < LINES; y++)
			lstore[y][c] = lstore[y+1][c];
		lstore[LINES-1][c] = pix;
		for (int y = 0; y < TAPS; y++) begin
			for (int x = 0; x + 1 < TAPS; x++)
				win[y*TAPS+x] = win[y*TAPS+x+1];
			win[y*TAPS+TAPS-1] = colpx[y];
		end
		last = col_cnt >= w - 1;
		emit = row_cnt >= LINES && col_cnt >= LINES;
		res = '0;
		if (emit) begin
			for (ch = 0; ch < 4; ch++) begin
				acc = 0;
				for (k = 0; k < NCOEF; k++)
					acc += longint'(win[k][8*ch +: 8]) * longint'(coef[k]);
				if (acc < 0) acc = 0;
				else begin
					acc = acc >>> FRAC_BITS;
					if (acc > 255) acc = 255;
				end
				res[8*ch +: 8] = acc[7:0];
			end
			res[32] = last;
		end
		if (last) begin
			col_cnt = 0;
			if (row_cnt < LINES) row_cnt++;
		end else
			col_cnt++;
	endfunction

	task automatic reg_write(input reg_idx_t idx, input logic [63:0] v);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = 6'(idx) << 3;
		pwdata = v;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		case (idx)
			REG_PADDED_WIDTH: width_reg = v[12:0];
			REG_COEF_LAST:    coef[NCOEF-1] = v[15:0];
			default:
				for (int j = 0; j < 4; j++)
					coef[4*(int'(idx)-1)+j] = v[16*j +: 16];
		endcase
	endtask

	// idle means nothing pending and the pipeline has had time to drain
	task automatic wait_idle();
		while (pending_out.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_coef(input coef_kind_t kind, input int k);
		logic [15:0] r;
		case (kind)
			K_IDENT:  r = (k == 12) ? 16'h1000 : 16'h0000;
			K_RAND:   r = 16'($urandom);
			K_MAXPOS: r = 16'h7fff;
			K_MAXNEG: r = 16'h8000;
			K_BOX:    r = 16'd164;
			default:  r = 16'($signed($urandom_range(0, 4096)) - 2048);
		endcase
		return r;
	endfunction

	task automatic configure(input logic [12:0] pw, input coef_kind_t kind);
		logic [63:0] pack;
		wait_idle();
		reg_write(REG_PADDED_WIDTH, 64'(pw));
		for (int p = 0; p < 6; p++) begin
			for (int j = 0; j < 4; j++)
				pack[16*j +: 16] = pick_coef(kind, 4*p + j);
			reg_write(reg_idx_t'(p + 1), pack);
		end
		reg_write(REG_COEF_LAST, 64'(pick_coef(kind, NCOEF - 1)));
		no_gaps = ($urandom_range(0, 3) == 0);
	endtask

	task automatic send_pixel(input logic [31:0] pix, input logic fs,
			input bit typed, input logic [32:0] want);
		bit emit;
		logic [32:0] res;
		if (!no_gaps && burst_left == 0) begin
			s_axis_tvalid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 20);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = pix;
		s_axis_tuser = fs;
		do @(posedge clk); while (!s_axis_tready);
		convolve_pixel(pix, fs, emit, res);
		if (typed) pending_out.push_back(want);
		else if (emit) pending_out.push_back(res);
		pixels_sent++;
		if (burst_left > 0) burst_left--;
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	function automatic logic [31:0] rand_pixel();
		logic [31:0] p;
		p = $urandom;
		for (int ch = 0; ch < 4; ch++)
			case ($urandom_range(0, 7))
				0: p[8*ch +: 8] = 8'h00;
				1: p[8*ch +: 8] = 8'hff;
				default: ;
			endcase
		return p;
	endfunction

	// a frame of random pixels; now and then a stray frame start breaks it
	task automatic send_frame(input int w, input int rows);
		for (int i = 0; i < w * rows; i++)
			send_pixel(rand_pixel(), (i == 0) || ($urandom_range(0, 60) == 0), 0, '0);
	endtask

	task automatic run_phase(input logic [12:0] pw, input coef_kind_t kind, input int frames);
		int w;
		configure(pw, kind);
		w = (pw < 5) ? 5 : (pw > MAX_WIDTH) ? MAX_WIDTH : int'(pw);
		for (int f = 0; f < frames; f++)
			send_frame(w, $urandom_range(5, 8));
	endtask

	// receiver stall pattern: ready always, at random, or mostly stalled
	always @(negedge clk) begin
		case ((cycles / 64) % 3)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= 1'($urandom_range(0, 1));
			default: m_axis_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	always @(posedge clk) begin
		logic [32:0] want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_out.size() == 0)
				report_err($sformatf("unexpected output transfer %h", m_axis_tdata));
			else begin
				want = pending_out.pop_front();
				for (int ch = 0; ch < 4; ch++)
					if (m_axis_tdata[8*ch +: 8] !== want[8*ch +: 8])
						report_err($sformatf("out_ch%0d got %h want %h", ch,
							m_axis_tdata[8*ch +: 8], want[8*ch +: 8]));
				if (m_axis_tlast !== want[32])
					report_err($sformatf("row_end got %b want %b", m_axis_tlast, want[32]));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	initial begin
		stim_row_t rows [25];
		for (int k = 0; k < NCOEF; k++)
			coef[k] = (k == 12) ? 16'sh1000 : 16'sh0000;
		for (int k = 0; k < NCOEF; k++)
			win[k] = '0;
		// 5x5 frame with identity taps: the single output is the centre pixel
		for (int i = 0; i < 25; i++) begin
			rows[i].pix = (i % 2) ? 32'hffff_ffff : 32'h0000_0000;
			rows[i].fs = (i == 0);
			rows[i].typed = 0;
			rows[i].want = '0;
		end
		rows[12].pix = 32'hff00_7f80;
		rows[24].typed = 1;
		rows[24].want = {1'b1, 32'hff00_7f80};
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		no_gaps = 0;
		reg_write(REG_PADDED_WIDTH, 64'd5);
		foreach (rows[i])
			send_pixel(rows[i].pix, rows[i].fs, rows[i].typed, rows[i].want);

		run_phase(13'd5, K_MAXPOS, 2);
		run_phase(13'd0, K_MAXNEG, 2);
		// oversized widths: clamped, no output within these few pixels
		configure(13'd8191, K_BOX);
		send_frame(30, 1);
		configure(13'd4096, K_RAND);
		send_frame(30, 1);
		run_phase(13'd12, K_BOX, 2);
		run_phase(13'd9, K_MILD, 2);
		run_phase(13'd7, K_IDENT, 1);
		while (pixels_sent < TARGET_PIXELS)
			run_phase(13'($urandom_range(5, 16)),
				coef_kind_t'($urandom_range(0, 5)), $urandom_range(1, 3));

		wait_idle();
		if (errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end
endmodule
`default_nettype wire
